// ===== sv/fse_pkg.sv =====
// ----------------------------------------------------------------------------
// fse_pkg
// Shared constants, types and helper functions of the format string engine.
// ----------------------------------------------------------------------------
package fse_pkg;

  localparam int MAX_DIGITS = 20;
  localparam int COUNT_BITS = 31;
  localparam int ARG_W      = 64;
  localparam int BCD_W      = 4 * MAX_DIGITS;
  localparam int LEN_W      = $clog2(MAX_DIGITS + 2);
  localparam int STEP_W     = $clog2(ARG_W + 1);
  localparam int TOT_W      = 31;

  localparam logic [2:0] KIND_FMT      = 3'd0;
  localparam logic [2:0] KIND_ARG      = 3'd1;
  localparam logic [2:0] KIND_STR_BYTE = 3'd2;
  localparam logic [2:0] KIND_STR_END  = 3'd3;
  localparam logic [2:0] KIND_FMT_END  = 3'd4;

  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_C     = 8'h63;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_P     = 8'h70;
  localparam logic [7:0] CH_S     = 8'h73;
  localparam logic [7:0] CH_Z     = 8'h7a;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_A_LOW = 8'h61;

  localparam logic [3:0] NIB_MASK = 4'hF;
  localparam logic [3:0] DEC_BASE = 4'd10;

  typedef enum logic [1:0] {RUN_NONE, RUN_LIT, RUN_DEC, RUN_HEX} run_t;

  typedef struct packed {
    logic       load;
    logic       setup;
    run_t       run_type;
    logic [7:0] lit0;
    logic [7:0] lit1;
    logic [7:0] lit2;
    logic [1:0] lit_len;
    logic       lit_from_arg;
    logic       conv_start;
    logic       dec_signed;
    logic       conv_step;
    logic       reserve;
    logic       set_err;
    logic       idx_clr;
    logic       emit_char;
    logic       char_last;
    logic       emit_fin;
    logic       emit_ovf;
    logic       clear;
  } cmd_t;

  typedef struct packed {
    logic [2:0]       kind;
    logic [7:0]       ch;
    logic             conv_done;
    logic [LEN_W-1:0] run_len;
    logic             fits;
    logic             err;
    logic             out_free;
    logic             idx_last;
  } st_t;

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < DEC_BASE) return CH_ZERO + {4'd0, n};
    else return CH_A_LOW + {4'd0, n} - {4'd0, DEC_BASE};
  endfunction

endpackage

// ===== sv/fse_dpath.sv =====
// ----------------------------------------------------------------------------
// fse_dpath
// Item latch, binary to decimal converter, character selection, count
// tracking and the result register.
// ----------------------------------------------------------------------------
module fse_dpath (
  input  logic                       clk,
  input  logic                       rst_n,
  input  fse_pkg::cmd_t              cmd,
  output fse_pkg::st_t               st,
  input  logic [2:0]                 in_kind,
  input  logic [7:0]                 in_char_in,
  input  logic [fse_pkg::ARG_W-1:0]  in_arg_value,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_has_char,
  output logic [7:0]                 out_char_out,
  output logic                       out_run_last,
  output logic                       out_finished,
  output logic [fse_pkg::TOT_W-1:0]  out_total_written,
  output logic                       out_overflow
);
  import fse_pkg::*;

  localparam logic [COUNT_BITS-1:0] LIMIT = {COUNT_BITS{1'b1}};

  logic [2:0]            kind_r;
  logic [7:0]            ch_r;
  logic [ARG_W-1:0]      arg_r;
  run_t                  run_r;
  logic [7:0]            lit0_r, lit1_r, lit2_r;
  logic [1:0]            lit_len_r;
  logic [ARG_W-1:0]      bin_r;
  logic [BCD_W-1:0]      bcd_r;
  logic                  trunc_r;
  logic                  neg_r;
  logic [STEP_W-1:0]     step_r;
  logic [COUNT_BITS-1:0] count_r;
  logic                  err_r;
  logic [LEN_W-1:0]      idx_r;

  logic                  ov_r;
  logic                  has_r, last_r, fin_r, ovf_r;
  logic [7:0]            char_r;
  logic [TOT_W-1:0]      tot_r;

  logic [BCD_W-1:0]      adj;
  logic [LEN_W-1:0]      ndig;
  logic [LEN_W-1:0]      run_len;
  logic [LEN_W-1:0]      dpos;
  logic [2:0]            hj;
  logic [7:0]            char_sel;
  logic [31:0]           mag32;
  logic                  out_free;
  logic [63:0]           count_wide;

  // add-3 correction ahead of each shift
  always_comb begin
    for (int k = 0; k < MAX_DIGITS; k++) begin
      if (bcd_r[4*k +: 4] >= 4'd5) adj[4*k +: 4] = bcd_r[4*k +: 4] + 4'd3;
      else adj[4*k +: 4] = bcd_r[4*k +: 4];
    end
  end

  always_comb begin
    ndig = LEN_W'(1);
    for (int k = 0; k < MAX_DIGITS; k++) begin
      if (bcd_r[4*k +: 4] != 4'd0) ndig = LEN_W'(k + 1);
    end
    if (trunc_r) ndig = LEN_W'(MAX_DIGITS);
  end

  always_comb begin
    case (run_r)
      RUN_LIT: run_len = LEN_W'(lit_len_r);
      RUN_DEC: run_len = ndig + LEN_W'(neg_r);
      RUN_HEX: run_len = LEN_W'(10);
      default: run_len = '0;
    endcase
  end

  always_comb begin
    dpos     = ndig - LEN_W'(1) - idx_r + LEN_W'(neg_r);
    hj       = 3'(idx_r - LEN_W'(2));
    char_sel = 8'd0;
    case (run_r)
      RUN_LIT: begin
        case (idx_r[1:0])
          2'd0:    char_sel = lit0_r;
          2'd1:    char_sel = lit1_r;
          default: char_sel = lit2_r;
        endcase
      end
      RUN_DEC: begin
        if (neg_r && idx_r == '0) char_sel = CH_MINUS;
        else char_sel = CH_ZERO + {4'd0, bcd_r[4*dpos +: 4] & NIB_MASK};
      end
      RUN_HEX: begin
        if (idx_r == LEN_W'(0)) char_sel = CH_ZERO;
        else if (idx_r == LEN_W'(1)) char_sel = CH_X;
        else char_sel = hex_char(arg_r[4*(3'd7 - hj) +: 4]);
      end
      default: char_sel = 8'd0;
    endcase
  end

  assign mag32      = arg_r[31] ? (~arg_r[31:0] + 32'd1) : arg_r[31:0];
  assign out_free   = !ov_r || !out_stall;
  assign count_wide = 64'(count_r);

  assign st.kind      = kind_r;
  assign st.ch        = ch_r;
  assign st.conv_done = (step_r == STEP_W'(ARG_W));
  assign st.run_len   = run_len;
  assign st.fits      = !err_r && ((LIMIT - count_r) >= COUNT_BITS'(run_len));
  assign st.err       = err_r;
  assign st.out_free  = out_free;
  assign st.idx_last  = (idx_r == run_len - LEN_W'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      err_r   <= 1'b0;
      ov_r    <= 1'b0;
      run_r   <= RUN_NONE;
    end else begin
      if (cmd.emit_char || cmd.emit_fin || cmd.emit_ovf) ov_r <= 1'b1;
      else if (!out_stall) ov_r <= 1'b0;
      if (cmd.setup) run_r <= cmd.run_type;
      if (cmd.reserve) count_r <= count_r + COUNT_BITS'(run_len);
      if (cmd.set_err) err_r <= 1'b1;
      if (cmd.clear) begin
        count_r <= '0;
        err_r   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= in_kind;
      ch_r   <= in_char_in;
      arg_r  <= in_arg_value;
    end
    if (cmd.setup) begin
      lit0_r    <= cmd.lit_from_arg ? arg_r[7:0] : cmd.lit0;
      lit1_r    <= cmd.lit1;
      lit2_r    <= cmd.lit2;
      lit_len_r <= cmd.lit_len;
    end
    // sign flag only matters for decimal runs, which always start a conversion
    if (cmd.conv_start) begin
      bin_r   <= cmd.dec_signed ? {32'd0, mag32} : arg_r;
      neg_r   <= cmd.dec_signed & arg_r[31];
      bcd_r   <= '0;
      trunc_r <= 1'b0;
      step_r  <= '0;
    end else if (cmd.conv_step) begin
      bcd_r   <= {adj[BCD_W-2:0], bin_r[ARG_W-1]};
      bin_r   <= {bin_r[ARG_W-2:0], 1'b0};
      trunc_r <= trunc_r | adj[BCD_W-1];
      step_r  <= step_r + STEP_W'(1);
    end
    if (cmd.idx_clr) idx_r <= '0;
    else if (cmd.emit_char) idx_r <= idx_r + LEN_W'(1);
    if (cmd.emit_char) begin
      has_r  <= 1'b1;
      char_r <= char_sel;
      last_r <= cmd.char_last;
      fin_r  <= 1'b0;
      tot_r  <= '0;
      ovf_r  <= 1'b0;
    end else if (cmd.emit_fin) begin
      has_r  <= 1'b0;
      char_r <= 8'd0;
      last_r <= 1'b1;
      fin_r  <= 1'b1;
      tot_r  <= err_r ? '0 : count_wide[TOT_W-1:0];
      ovf_r  <= err_r;
    end else if (cmd.emit_ovf) begin
      has_r  <= 1'b0;
      char_r <= 8'd0;
      last_r <= 1'b1;
      fin_r  <= 1'b0;
      tot_r  <= '0;
      ovf_r  <= 1'b1;
    end
  end

  assign out_valid         = ov_r;
  assign out_has_char      = has_r;
  assign out_char_out      = char_r;
  assign out_run_last      = last_r;
  assign out_finished      = fin_r;
  assign out_total_written = tot_r;
  assign out_overflow      = ovf_r;

endmodule

// ===== sv/fse_ctrl.sv =====
// ----------------------------------------------------------------------------
// fse_ctrl
// Format parser and sequencer: decodes each transaction, runs the decimal
// conversion, checks the count limit and steps through the results.
// ----------------------------------------------------------------------------
module fse_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output fse_pkg::cmd_t cmd,
  input  fse_pkg::st_t  st
);
  import fse_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_DECODE, S_CONV, S_CHECK, S_EMIT, S_FIN, S_OVF
  } state_t;

  typedef enum logic [2:0] {
    M_LIT, M_PCT, M_Z, M_ARG, M_STR, M_VERB
  } mode_t;

  typedef enum logic [1:0] {SP_C, SP_D, SP_P, SP_ZU} spec_t;

  state_t state_r, state_nxt;
  mode_t  mode_r, mode_nxt;
  spec_t  spec_r, spec_nxt;
  logic   fin_r, fin_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    mode_nxt  = mode_r;
    spec_nxt  = spec_r;
    fin_nxt   = fin_r;
    in_stall  = (state_r != S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.setup    = 1'b1;
        cmd.run_type = RUN_NONE;
        cmd.lit0     = st.ch;
        cmd.lit_len  = 2'd1;
        fin_nxt      = 1'b0;
        state_nxt    = S_CHECK;
        case (st.kind)
          KIND_FMT: begin
            case (mode_r)
              M_LIT: begin
                if (st.ch == CH_PCT) mode_nxt = M_PCT;
                else cmd.run_type = RUN_LIT;
              end
              M_PCT: begin
                if (st.ch == CH_PCT) begin
                  cmd.run_type = RUN_LIT;
                  mode_nxt     = M_LIT;
                end else if (st.ch == CH_C) begin
                  spec_nxt = SP_C;
                  mode_nxt = M_ARG;
                end else if (st.ch == CH_D) begin
                  spec_nxt = SP_D;
                  mode_nxt = M_ARG;
                end else if (st.ch == CH_P) begin
                  spec_nxt = SP_P;
                  mode_nxt = M_ARG;
                end else if (st.ch == CH_S) begin
                  mode_nxt = M_STR;
                end else if (st.ch == CH_Z) begin
                  mode_nxt = M_Z;
                end else begin
                  cmd.run_type = RUN_LIT;
                  cmd.lit0     = CH_PCT;
                  cmd.lit1     = st.ch;
                  cmd.lit_len  = 2'd2;
                  mode_nxt     = M_VERB;
                end
              end
              M_Z: begin
                if (st.ch == CH_U) begin
                  spec_nxt = SP_ZU;
                  mode_nxt = M_ARG;
                end else begin
                  cmd.run_type = RUN_LIT;
                  cmd.lit0     = CH_PCT;
                  cmd.lit1     = CH_Z;
                  cmd.lit2     = st.ch;
                  cmd.lit_len  = 2'd3;
                  mode_nxt     = M_VERB;
                end
              end
              M_VERB: cmd.run_type = RUN_LIT;
              default: ;
            endcase
          end
          KIND_ARG: begin
            if (mode_r == M_ARG) begin
              mode_nxt = M_LIT;
              case (spec_r)
                SP_C: begin
                  cmd.run_type     = RUN_LIT;
                  cmd.lit_from_arg = 1'b1;
                end
                SP_D: begin
                  cmd.run_type   = RUN_DEC;
                  cmd.conv_start = 1'b1;
                  cmd.dec_signed = 1'b1;
                  state_nxt      = S_CONV;
                end
                SP_P: cmd.run_type = RUN_HEX;
                default: begin
                  cmd.run_type   = RUN_DEC;
                  cmd.conv_start = 1'b1;
                  state_nxt      = S_CONV;
                end
              endcase
            end
          end
          KIND_STR_BYTE: begin
            if (mode_r == M_STR) cmd.run_type = RUN_LIT;
          end
          KIND_STR_END: begin
            if (mode_r == M_STR) mode_nxt = M_LIT;
          end
          KIND_FMT_END: begin
            fin_nxt = 1'b1;
            if (mode_r == M_PCT) begin
              cmd.run_type = RUN_LIT;
              cmd.lit0     = CH_PCT;
            end else if (mode_r == M_Z) begin
              cmd.run_type = RUN_LIT;
              cmd.lit0     = CH_PCT;
              cmd.lit1     = CH_Z;
              cmd.lit_len  = 2'd2;
            end
          end
          default: ;
        endcase
      end
      S_CONV: begin
        if (st.conv_done) state_nxt = S_CHECK;
        else cmd.conv_step = 1'b1;
      end
      S_CHECK: begin
        cmd.idx_clr = 1'b1;
        if (st.run_len != '0 && st.fits) begin
          cmd.reserve = 1'b1;
          state_nxt   = S_EMIT;
        end else if (fin_r) begin
          state_nxt = S_FIN;
        end else if (st.run_len != '0 && !st.err) begin
          // first overflow of this call reports once
          cmd.set_err = 1'b1;
          state_nxt   = S_OVF;
        end else begin
          state_nxt = S_IDLE;
        end
        if (st.run_len != '0 && !st.fits && !st.err) cmd.set_err = 1'b1;
      end
      S_EMIT: begin
        if (st.out_free) begin
          cmd.emit_char = 1'b1;
          cmd.char_last = st.idx_last & !fin_r;
          if (st.idx_last) state_nxt = fin_r ? S_FIN : S_IDLE;
        end
      end
      S_FIN: begin
        if (st.out_free) begin
          cmd.emit_fin = 1'b1;
          cmd.clear    = 1'b1;
          mode_nxt     = M_LIT;
          spec_nxt     = SP_C;
          state_nxt    = S_IDLE;
        end
      end
      S_OVF: begin
        if (st.out_free) begin
          cmd.emit_ovf = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      mode_r  <= M_LIT;
      spec_r  <= SP_C;
      fin_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      mode_r  <= mode_nxt;
      spec_r  <= spec_nxt;
      fin_r   <= fin_nxt;
    end
  end

endmodule

// ===== sv/format_string_engine_unit.sv =====
// ----------------------------------------------------------------------------
// format_string_engine_unit
// Streaming printf subset: literal text, %%, %c, %d, %p, %s and %zu.
// ----------------------------------------------------------------------------
// One transaction is taken at a time. A transaction's characters leave through
// the output register one character a cycle while the output does not stall.
// %d and %zu first run a shift-and-add-3 binary to decimal converter that
// handles one argument bit a cycle. Format end adds a finished result after
// the characters. Output stalls hold the sequencer in place.
module format_string_engine_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [2:0]                 in_kind,
  input  logic [7:0]                 in_char_in,
  input  logic [fse_pkg::ARG_W-1:0]  in_arg_value,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_has_char,
  output logic [7:0]                 out_char_out,
  output logic                       out_run_last,
  output logic                       out_finished,
  output logic [fse_pkg::TOT_W-1:0]  out_total_written,
  output logic                       out_overflow
);
  import fse_pkg::*;

  cmd_t cmd;
  st_t  st;

  fse_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .st       (st)
  );

  fse_dpath u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .st                (st),
    .in_kind           (in_kind),
    .in_char_in        (in_char_in),
    .in_arg_value      (in_arg_value),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_has_char      (out_has_char),
    .out_char_out      (out_char_out),
    .out_run_last      (out_run_last),
    .out_finished      (out_finished),
    .out_total_written (out_total_written),
    .out_overflow      (out_overflow)
  );

endmodule

// ===== sv/fse_checker.sv =====
// ----------------------------------------------------------------------------
// fse_checker
// Port level checks of the format string engine result stream.
// ----------------------------------------------------------------------------
module fse_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_has_char,
  input logic [7:0]  out_char_out,
  input logic        out_run_last,
  input logic        out_finished,
  input logic [30:0] out_total_written,
  input logic        out_overflow
);

  // a finished result always closes its transaction
  a_fin_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_finished |-> out_run_last)
    else $error("finished result without run_last");

  // characters never carry finish or overflow
  a_char_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_has_char |-> !out_finished && !out_overflow)
    else $error("character result flagged finished or overflow");

  // count only appears on a clean finish
  a_tot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (!out_finished || out_overflow) |-> out_total_written == 31'd0)
    else $error("total_written nonzero outside clean finish");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_char_out))
    else $error("stalled result changed");

endmodule

bind format_string_engine_unit fse_checker u_fse_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_has_char      (out_has_char),
  .out_char_out      (out_char_out),
  .out_run_last      (out_run_last),
  .out_finished      (out_finished),
  .out_total_written (out_total_written),
  .out_overflow      (out_overflow)
);

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for format_string_engine_unit: directed and random
// format streams, a behavioral predictor and an in-order result scoreboard.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

typedef struct packed {
  logic        has_char;
  logic [7:0]  char_out;
  logic        run_last;
  logic        finished;
  logic [30:0] total_written;
  logic        overflow;
} fmt_result_t;

class fmt_scoreboard;
  typedef enum int {PM_LIT, PM_PCT, PM_Z, PM_ARG, PM_STR, PM_VERB} pmode_t;
  typedef enum int {SP_C, SP_D, SP_P, SP_ZU} spec_t;
  pmode_t      mode;
  spec_t       spec;
  longint unsigned count;
  bit          err;
  fmt_result_t pending_chars[$];
  int          mismatches;

  function new();
    clear_call();
    mismatches = 0;
  endfunction

  function void clear_call();
    mode = PM_LIT;
    spec = SP_C;
    count = 0;
    err = 0;
  endfunction

  // decimal digits of v, most significant first, at most 20 kept
  function automatic void push_dec(ref byte unsigned txt[$], input logic [63:0] v);
    byte unsigned digs[$];
    int n;
    n = 0;
    do begin
      digs.push_front(8'h30 + byte'(v % 10));
      v = v / 10;
      n++;
    end while (v != 0 && n < fse_pkg::MAX_DIGITS);
    foreach (digs[i]) txt.push_back(digs[i]);
  endfunction

  function void note_input(logic [2:0] kind, logic [7:0] ch, logic [63:0] arg);
    byte unsigned txt[$];
    bit was_err, fin;
    fmt_result_t r;
    logic [31:0] v;
    logic [3:0] nib;
    was_err = err;
    fin = 0;
    if (kind == fse_pkg::KIND_FMT) begin
      case (mode)
        PM_LIT: if (ch == fse_pkg::CH_PCT) mode = PM_PCT; else txt.push_back(ch);
        PM_PCT: begin
          if (ch == fse_pkg::CH_PCT) begin txt.push_back(ch); mode = PM_LIT; end
          else if (ch == fse_pkg::CH_C) begin spec = SP_C; mode = PM_ARG; end
          else if (ch == fse_pkg::CH_D) begin spec = SP_D; mode = PM_ARG; end
          else if (ch == fse_pkg::CH_P) begin spec = SP_P; mode = PM_ARG; end
          else if (ch == fse_pkg::CH_S) mode = PM_STR;
          else if (ch == fse_pkg::CH_Z) mode = PM_Z;
          else begin txt.push_back(fse_pkg::CH_PCT); txt.push_back(ch); mode = PM_VERB; end
        end
        PM_Z: begin
          if (ch == fse_pkg::CH_U) begin spec = SP_ZU; mode = PM_ARG; end
          else begin
            txt.push_back(fse_pkg::CH_PCT); txt.push_back(fse_pkg::CH_Z);
            txt.push_back(ch); mode = PM_VERB;
          end
        end
        PM_VERB: txt.push_back(ch);
        default: ;
      endcase
    end else if (kind == fse_pkg::KIND_ARG && mode == PM_ARG) begin
      case (spec)
        SP_C: txt.push_back(arg[7:0]);
        SP_D: begin
          v = arg[31:0];
          if (v[31]) begin txt.push_back(fse_pkg::CH_MINUS); v = -v; end
          push_dec(txt, {32'd0, v});
        end
        SP_P: begin
          txt.push_back(fse_pkg::CH_ZERO); txt.push_back(fse_pkg::CH_X);
          for (int i = 7; i >= 0; i--) begin
            nib = arg[4*i +: 4];
            txt.push_back(8'(nib < 4'd10 ? 8'h30 + nib : 8'h61 + nib - 8'd10));
          end
        end
        default: push_dec(txt, arg);
      endcase
      mode = PM_LIT;
    end else if (kind == fse_pkg::KIND_STR_BYTE && mode == PM_STR) begin
      txt.push_back(ch);
    end else if (kind == fse_pkg::KIND_STR_END && mode == PM_STR) begin
      mode = PM_LIT;
    end else if (kind == fse_pkg::KIND_FMT_END) begin
      if (mode == PM_PCT) txt.push_back(fse_pkg::CH_PCT);
      else if (mode == PM_Z) begin
        txt.push_back(fse_pkg::CH_PCT); txt.push_back(fse_pkg::CH_Z);
      end
      fin = 1;
    end
    if (txt.size() > 0) begin
      if (err) txt.delete();
      else if (((64'd1 << fse_pkg::COUNT_BITS) - 1) - count < txt.size()) begin
        err = 1; txt.delete();
      end else count += txt.size();
    end
    foreach (txt[i]) begin
      r = '{1'b1, txt[i], 1'b0, 1'b0, 31'd0, err};
      pending_chars.push_back(r);
    end
    if (fin) begin
      r = '{1'b0, 8'd0, 1'b0, 1'b1, err ? 31'd0 : count[30:0], err};
      pending_chars.push_back(r);
      clear_call();
    end else if (!was_err && err && txt.size() == 0) begin
      r = '{1'b0, 8'd0, 1'b0, 1'b0, 31'd0, 1'b1};
      pending_chars.push_back(r);
    end
    if (txt.size() > 0 || fin || (!was_err && err))
      pending_chars[$].run_last = 1;
  endfunction

  function void check_result(fmt_result_t got);
    fmt_result_t exp;
    if (pending_chars.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result: char=%h fin=%b", got.char_out, got.finished);
      return;
    end
    exp = pending_chars.pop_front();
    if (exp != got) begin
      mismatches++;
      if (mismatches <= 10)
        $display({"mismatch exp has=%b ch=%h last=%b fin=%b tot=%0d ovf=%b",
                  " | got has=%b ch=%h last=%b fin=%b tot=%0d ovf=%b"},
                 exp.has_char, exp.char_out, exp.run_last, exp.finished,
                 exp.total_written, exp.overflow, got.has_char, got.char_out,
                 got.run_last, got.finished, got.total_written, got.overflow);
    end
  endfunction
endclass

module testbench;
  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_stall;
  logic [2:0]  in_kind = '0;
  logic [7:0]  in_char_in = '0;
  logic [63:0] in_arg_value = '0;
  logic        out_valid;
  logic        out_stall = 1;
  logic        out_has_char;
  logic [7:0]  out_char_out;
  logic        out_run_last;
  logic        out_finished;
  logic [30:0] out_total_written;
  logic        out_overflow;

  fmt_scoreboard sb = new();
  bit stim_done = 0;
  bit calm = 0;

  always #6 clk = ~clk;

  format_string_engine_unit u_dut (.*);

  // valid drops only when a gap follows, so back to back drives never clash
  task automatic send(logic [2:0] kind, logic [7:0] ch, logic [63:0] arg);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1; in_kind <= kind; in_char_in <= ch; in_arg_value <= arg;
    do @(posedge clk); while (in_stall);
    sb.note_input(kind, ch, arg);
  endtask

  task automatic fmt_str(string s);
    foreach (s[i]) send(fse_pkg::KIND_FMT, s[i], 64'd0);
  endtask

  function automatic logic [63:0] rand_arg();
    case ($urandom_range(0, 5))
      0: return 64'd0;
      1: return 64'hFFFF_FFFF_FFFF_FFFF;
      2: return 64'h0000_0000_8000_0000;
      3: return 64'($urandom_range(0, 999));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // output side: random stalls, check on accepted transactions
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall)
        sb.check_result('{out_has_char, out_char_out, out_run_last, out_finished,
                          out_total_written, out_overflow});
      out_stall <= calm ? 1'b0 : ($urandom_range(0, 16) < 4);
    end
  end

  initial begin
    int items;
    int nstr;
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed
    fmt_str("a%%"); send(fse_pkg::KIND_FMT, 8'h00, 64'd0);
    send(fse_pkg::KIND_FMT, 8'hFF, 64'd0);
    fmt_str("%c"); send(fse_pkg::KIND_ARG, 8'd0, 64'hFFFF_FFFF_FFFF_FF41);
    fmt_str("%d"); send(fse_pkg::KIND_ARG, 8'd0, 64'h0000_0000_8000_0000);
    fmt_str("%d"); send(fse_pkg::KIND_ARG, 8'd0, 64'hFFFF_FFFF_7FFF_FFFF);
    fmt_str("%p"); send(fse_pkg::KIND_ARG, 8'd0, 64'h1234_5678_9ABC_DEF0);
    fmt_str("%zu"); send(fse_pkg::KIND_ARG, 8'd0, 64'hFFFF_FFFF_FFFF_FFFF);
    send(fse_pkg::KIND_ARG, 8'd0, 64'd1);
    fmt_str("%s"); send(fse_pkg::KIND_FMT, "q", 64'd0);
    send(fse_pkg::KIND_STR_BYTE, 8'hFF, 64'd0); send(fse_pkg::KIND_STR_END, 8'd0, 64'd0);
    send(3'd7, 8'd0, 64'd0);
    fmt_str("%zq%k"); send(fse_pkg::KIND_FMT_END, 8'd0, 64'd0);
    fmt_str("%z"); send(fse_pkg::KIND_FMT_END, 8'd0, 64'd0);
    fmt_str("%"); send(fse_pkg::KIND_FMT_END, 8'd0, 64'd0);
    fmt_str("%d"); send(fse_pkg::KIND_FMT_END, 8'd0, 64'd0);
    // random: mostly well-formed pieces
    items = 0;
    while (items < 160) begin
      calm = ($urandom_range(0, 7) == 0);
      case ($urandom_range(0, 9))
        0, 1: begin send(fse_pkg::KIND_FMT, 8'($urandom), 64'd0); items++; end
        2: begin fmt_str("%c"); send(fse_pkg::KIND_ARG, 8'd0, rand_arg()); items += 3; end
        3: begin fmt_str("%d"); send(fse_pkg::KIND_ARG, 8'd0, rand_arg()); items += 3; end
        4: begin fmt_str("%p"); send(fse_pkg::KIND_ARG, 8'd0, rand_arg()); items += 3; end
        5: begin fmt_str("%zu"); send(fse_pkg::KIND_ARG, 8'd0, rand_arg()); items += 4; end
        6: begin
          fmt_str("%s");
          nstr = $urandom_range(0, 4);
          repeat (nstr) send(fse_pkg::KIND_STR_BYTE, 8'($urandom), 64'd0);
          send(fse_pkg::KIND_STR_END, 8'd0, 64'd0); items += 3 + nstr;
        end
        7: begin send(fse_pkg::KIND_FMT_END, 8'd0, 64'd0); items++; end
        8: begin
          send(3'($urandom_range(0, 7)), 8'($urandom), {$urandom, $urandom});
          items++;
        end
        default: begin fmt_str("%%"); items += 2; end
      endcase
    end
    send(fse_pkg::KIND_FMT_END, 8'd0, 64'd0);
    in_valid <= 0;
    calm = 1;
    stim_done = 1;
  end

  initial begin
    wait (stim_done);
    while (sb.pending_chars.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_chars.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #20ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
